// ----- src/brfc_pkg.sv -----
// Package for the bridge reply frame checker.
// Holds payload and config types, frame constants, the CRC byte step and the
// status mapping. No dependencies.
package brfc_pkg;

	localparam int MAX_FRAME_BYTES = 64;
	localparam int COUNT_W = $clog2(MAX_FRAME_BYTES + 2);

	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [7:0] WIRE_NOT_READY = 8'h80;
	localparam logic [7:0] WIRE_MAX_DIRECT = 8'h08;

	localparam logic CFG_IDX_MODE  = 1'b0;
	localparam logic CFG_IDX_START = 1'b1;

	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_BAD_START = 3'd1;
	localparam logic [2:0] ERR_TOO_SHORT = 3'd2;
	localparam logic [2:0] ERR_TOO_LONG  = 3'd3;
	localparam logic [2:0] ERR_CRC       = 3'd4;

	localparam logic [3:0] ST_OK        = 4'd0;
	localparam logic [3:0] ST_NOT_READY = 4'd2;
	localparam logic [3:0] ST_IO        = 4'd5;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       last_byte;
	} brfc_in_t;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       payload_valid;
		logic       frame_done;
		logic [2:0] frame_error;
		logic [3:0] result_status;
	} brfc_out_t;

	typedef struct packed {
		logic       transport_mode;
		logic [7:0] start_byte;
	} brfc_cfg_t;

	// CRC-16/CCITT-FALSE, one byte, MSB first
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

	function automatic logic [3:0] map_status(input logic [7:0] s);
		logic [3:0] r;
		if (s <= WIRE_MAX_DIRECT) begin
			r = s[3:0];
		end else if (s == WIRE_NOT_READY) begin
			r = ST_NOT_READY;
		end else begin
			r = ST_IO;
		end
		return r;
	endfunction

endpackage

// ----- src/bridge_reply_frame_checker_core.sv -----
// Top level of the bridge reply frame checker: config registers, frame logic
// and the result register. Depends on brfc_pkg and brfc_frame.
// An accepted byte's result is registered and appears on the output in the next cycle.
// Throughput: one byte per cycle unless the sink stalls; the byte-wide CRC step
// and the frame checks sit between the frame state and the result register.
// Reset: arst_n clears config to SPI mode with start byte 0, returns the frame
// state to its idle values and empties the result register.
module bridge_reply_frame_checker_core import brfc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  brfc_in_t   in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output brfc_out_t  out_data,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_wdata
);

	brfc_cfg_t cfg_q;
	brfc_out_t result;
	brfc_out_t out_data_q;
	logic      out_valid_q;
	logic      accept;

	// Take a new transaction whenever the result register is empty or being drained.
	assign in_ready = ~out_valid_q | out_ready;
	assign accept   = in_valid & in_ready;

	// Config writes land immediately; index selects the register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_IDX_MODE:  cfg_q.transport_mode <= cfg_wdata[0];
				CFG_IDX_START: cfg_q.start_byte     <= cfg_wdata;
				default:       cfg_q                <= cfg_q;
			endcase
		end
	end

	brfc_frame u_frame (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.accept  (accept),
		.in_data (in_data),
		.result  (result)
	);

	// Result register: load on accept, drop valid once the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ----- src/brfc_frame.sv -----
// Frame state and per-byte result logic for the reply frame checker.
// Depends on brfc_pkg (types, CRC step, status mapping).
module brfc_frame import brfc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  brfc_cfg_t cfg,
	input  logic      accept,
	input  brfc_in_t  in_data,
	output brfc_out_t result
);

	localparam logic [COUNT_W-1:0] CNT_MAX  = COUNT_W'(MAX_FRAME_BYTES);
	localparam logic [COUNT_W-1:0] CNT_SAT  = COUNT_W'(MAX_FRAME_BYTES + 1);
	localparam logic [COUNT_W-1:0] CNT_TWO  = COUNT_W'(2);

	logic [15:0]        crc_q, crc_n;
	logic [COUNT_W-1:0] count_q, count_n;
	logic [7:0]         dly0_q, dly0_n, dly1_q, dly1_n;
	logic [7:0]         wstat_q, wstat_n;
	logic               start_ok_q, start_ok_n;

	logic               spi;
	logic [COUNT_W-1:0] hdr;

	always_comb begin
		spi        = ~cfg.transport_mode;
		hdr        = spi ? COUNT_W'(2) : COUNT_W'(1);
		crc_n      = crc_q;
		count_n    = count_q;
		dly0_n     = dly0_q;
		dly1_n     = dly1_q;
		wstat_n    = wstat_q;
		start_ok_n = start_ok_q;
		result     = '0;

		if (count_q >= CNT_MAX) begin
			// overlong frame: drop bytes until the last one
			if (in_data.last_byte) begin
				result.frame_done  = 1'b1;
				result.frame_error = ERR_TOO_LONG;
			end else begin
				count_n = CNT_SAT;
			end
		end else begin
			if (count_q >= CNT_TWO) begin
				crc_n = crc16_byte(crc_q, dly1_q);
				if (spi && count_q == CNT_TWO) begin
					start_ok_n = (dly1_q == cfg.start_byte);
				end
				if (count_q == hdr + COUNT_W'(1)) begin
					wstat_n = dly1_q;
				end
				if (count_q >= hdr + CNT_TWO) begin
					result.payload_byte  = dly1_q;
					result.payload_valid = 1'b1;
				end
			end
			dly1_n  = dly0_q;
			dly0_n  = in_data.rx_byte;
			count_n = count_q + COUNT_W'(1);

			if (in_data.last_byte) begin
				result.frame_done = 1'b1;
				if (count_q < hdr + COUNT_W'(1)) begin
					result.frame_error = ERR_TOO_SHORT;
				end else if (spi && !start_ok_n) begin
					result.frame_error = ERR_BAD_START;
				end else if ({in_data.rx_byte, dly0_q} != crc_n) begin
					result.frame_error = ERR_CRC;
				end else begin
					result.result_status = map_status(wstat_n);
				end
			end
		end

		// frame end: return to the idle frame state
		if (in_data.last_byte) begin
			crc_n      = CRC_INIT;
			count_n    = '0;
			dly0_n     = '0;
			dly1_n     = '0;
			wstat_n    = '0;
			start_ok_n = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q      <= CRC_INIT;
			count_q    <= '0;
			dly0_q     <= '0;
			dly1_q     <= '0;
			wstat_q    <= '0;
			start_ok_q <= 1'b1;
		end else if (accept) begin
			crc_q      <= crc_n;
			count_q    <= count_n;
			dly0_q     <= dly0_n;
			dly1_q     <= dly1_n;
			wstat_q    <= wstat_n;
			start_ok_q <= start_ok_n;
		end
	end

endmodule
